### rtl/utf8_to_glyph_byte_transcoder_core_macros.svh
// Assertion macros for the UTF-8 to glyph byte transcoder.
// Included by the top level; no other dependencies.
`ifndef UTF8_TO_GLYPH_BYTE_TRANSCODER_CORE_MACROS_SVH
`define UTF8_TO_GLYPH_BYTE_TRANSCODER_CORE_MACROS_SVH

// same-cycle implication
`define U2G_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("u2g assertion failed");

// next-cycle implication
`define U2G_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("u2g assertion failed");

`endif

### rtl/u2gbt_pkg.sv
// Package for the UTF-8 to glyph byte transcoder: widths, constants, glyph ROMs.
// No dependencies.
package u2gbt_pkg;

   localparam int COUNT_BITS_DEF = 16;
   localparam int BYTE_W         = 8;
   localparam int CODE_W         = 16;
   localparam int LIMIT_W        = 16;
   localparam int WCOUNT_W       = 16;
   localparam int DATA_W         = 32;
   localparam int ADDR_W         = 3;

   localparam logic [LIMIT_W-1:0] LIMIT_RESET = 16'hFFFF;

   localparam logic [ADDR_W-1:2] REG_OUTPUT_LIMIT = 1'b0;

   localparam logic [CODE_W-1:0] ASCII_LO = 16'h0020;
   localparam logic [CODE_W-1:0] ASCII_HI = 16'h007E;
   localparam logic [CODE_W-1:0] CYR_LO   = 16'h0400;
   localparam logic [CODE_W-1:0] CYR_HI   = 16'h04FF;
   localparam int ASCII_ROM_N = 32;
   localparam int CYR_ROM_N   = 82;

   localparam logic [BYTE_W-1:0] ASCII_ROM [ASCII_ROM_N] = '{
      8'h5F, 8'h00, 8'h5D, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
      8'h28, 8'h29, 8'h40, 8'h2B, 8'h2C, 8'h2D, 8'h2E, 8'h2F,
      8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37,
      8'h38, 8'h39, 8'h3A, 8'h00, 8'h00, 8'h00, 8'h00, 8'h3F
   };

   localparam logic [BYTE_W-1:0] CYR_ROM [CYR_ROM_N] = '{
      8'h00, 8'h46, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
      8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
      8'h41, 8'h42, 8'h43, 8'h44, 8'h45, 8'h46, 8'h47, 8'h48,
      8'h49, 8'h4A, 8'h4B, 8'h4C, 8'h4D, 8'h4E, 8'h4F, 8'h50,
      8'h51, 8'h52, 8'h53, 8'h54, 8'h55, 8'h56, 8'h57, 8'h58,
      8'h59, 8'h5A, 8'h5B, 8'h5C, 8'h00, 8'h3C, 8'h3D, 8'h3E,
      8'h27, 8'h2A, 8'h5E, 8'h3B, 8'h61, 8'h66, 8'h62, 8'h63,
      8'h64, 8'h65, 8'h4B, 8'h67, 8'h68, 8'h69, 8'h6A, 8'h6B,
      8'h6C, 8'h6D, 8'h6E, 8'h6F, 8'h70, 8'h79, 8'h72, 8'h73,
      8'h74, 8'h75, 8'h76, 8'h77, 8'h78, 8'h71, 8'h7A, 8'h3E,
      8'h00, 8'h66
   };

   // code point to glyph byte; 0 means no glyph
   function automatic logic [BYTE_W-1:0] map_code(input logic [CODE_W-1:0] cp);
      logic [CODE_W-1:0] idx;
      logic [BYTE_W-1:0] g;
      g = '0;
      if (cp >= ASCII_LO && cp <= ASCII_HI) begin
         idx = cp - ASCII_LO;
         if (idx < CODE_W'(ASCII_ROM_N))
            g = ASCII_ROM[idx[4:0]];
      end else if (cp >= CYR_LO && cp <= CYR_HI) begin
         idx = cp - CYR_LO;
         if (idx < CODE_W'(CYR_ROM_N))
            g = CYR_ROM[idx[6:0]];
      end
      return g;
   endfunction

endpackage

### rtl/utf8_to_glyph_byte_transcoder_core.sv
// Top level of the UTF-8 to glyph byte transcoder.
// Uses u2gbt_pkg and utf8_to_glyph_byte_transcoder_core_macros.svh.
//
// One text byte in, one result beat out, one byte per cycle unless req_stall
// holds the input. Each byte is decoded and mapped in the cycle it is accepted
// and its result is held in the output register, valid from the next cycle. A
// new byte is taken in the same cycle the held result leaves; req_stall follows
// rsp_stall in the same cycle while a result is held.
// output_limit caps the glyphs of each string; string_last clears the state.
module utf8_to_glyph_byte_transcoder_core #(
   parameter int COUNT_BITS = u2gbt_pkg::COUNT_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [u2gbt_pkg::BYTE_W-1:0]      req_text_byte,
   input  logic                              req_string_last,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic                              rsp_glyph_valid,
   output logic [u2gbt_pkg::BYTE_W-1:0]      rsp_glyph_byte,
   output logic                              rsp_string_done,
   output logic [u2gbt_pkg::WCOUNT_W-1:0]    rsp_written_count,
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [u2gbt_pkg::ADDR_W-1:0]      paddr,
   input  logic [u2gbt_pkg::DATA_W-1:0]      pwdata,
   output logic [u2gbt_pkg::DATA_W-1:0]      prdata,
   output logic                              pready
);
   import u2gbt_pkg::*;

   localparam int CMP_W = (COUNT_BITS > LIMIT_W) ? COUNT_BITS : LIMIT_W;
   localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

   logic [LIMIT_W-1:0]    limit_ff;
   logic [1:0]            pend_ff, pend_in;
   logic [CODE_W-1:0]     code_ff, code_in;
   logic [COUNT_BITS-1:0] count_ff, count_in;

   logic                  rsp_valid_ff;
   logic                  gvalid_ff, gvalid_in;
   logic [BYTE_W-1:0]     gbyte_ff, gbyte_in;
   logic                  done_ff;
   logic [WCOUNT_W-1:0]   wcount_ff, wcount_in;

   logic                  accept, csr_wr, room, is_cont, cp_done;
   logic                  last_beat, body_beat;
   logic [1:0]            pend_dec;
   logic [CODE_W-1:0]     code_dec, cp;
   logic [BYTE_W-1:0]     glyph;

   // config port
   assign pready = 1'b1;
   assign csr_wr = psel & penable & pwrite;
   assign prdata = (paddr[ADDR_W-1:2] == REG_OUTPUT_LIMIT) ?
                   DATA_W'(limit_ff) : '0;

   assign req_stall = rsp_valid_ff & rsp_stall;
   assign accept    = req_valid & ~req_stall;

   assign room = (CMP_W'(count_ff) < CMP_W'(limit_ff)) && (count_ff != COUNT_MAX);
   assign is_cont = (req_text_byte[7:6] == 2'b10);

   always_comb begin
      pend_dec = pend_ff;
      code_dec = code_ff;
      cp       = '0;
      cp_done  = 1'b0;
      if (pend_ff != 2'd0 && is_cont) begin
         code_dec = {code_ff[CODE_W-7:0], req_text_byte[5:0]};
         pend_dec = pend_ff - 2'd1;
         if (pend_ff == 2'd1) begin
            cp      = code_dec;
            cp_done = 1'b1;
         end
      end else begin
         if (pend_ff != 2'd0) begin
            pend_dec = 2'd0;
            code_dec = '0;
         end
         if (req_text_byte[7] == 1'b0) begin
            cp      = CODE_W'(req_text_byte);
            cp_done = 1'b1;
         end else if (req_text_byte[7:5] == 3'b110) begin
            code_dec = CODE_W'(req_text_byte[4:0]);
            pend_dec = 2'd1;
         end else if (req_text_byte[7:4] == 4'b1110) begin
            code_dec = CODE_W'(req_text_byte[3:0]);
            pend_dec = 2'd2;
         end
      end
      glyph = map_code(cp);
   end

   always_comb begin
      pend_in   = pend_ff;
      code_in   = code_ff;
      count_in  = count_ff;
      gvalid_in = 1'b0;
      gbyte_in  = '0;
      if (room) begin
         pend_in = pend_dec;
         code_in = code_dec;
         if (cp_done && cp != '0 && glyph != '0) begin
            gvalid_in = 1'b1;
            gbyte_in  = glyph;
            count_in  = count_ff + COUNT_BITS'(1);
         end
      end
      wcount_in = WCOUNT_W'(count_in);
      if (req_string_last) begin
         pend_in  = 2'd0;
         code_in  = '0;
         count_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff     <= LIMIT_RESET;
         pend_ff      <= 2'd0;
         code_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr && paddr[ADDR_W-1:2] == REG_OUTPUT_LIMIT)
            limit_ff <= pwdata[LIMIT_W-1:0];
         if (accept) begin
            pend_ff  <= pend_in;
            code_ff  <= code_in;
            count_ff <= count_in;
         end
         if (accept)
            rsp_valid_ff <= 1'b1;
         else if (~rsp_stall)
            rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         gvalid_ff <= gvalid_in;
         gbyte_ff  <= gbyte_in;
         done_ff   <= req_string_last;
         wcount_ff <= wcount_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_glyph_valid   = gvalid_ff;
   assign rsp_glyph_byte    = gbyte_ff;
   assign rsp_string_done   = done_ff;
   assign rsp_written_count = wcount_ff;

   assign last_beat = accept & req_string_last;
   assign body_beat = accept & ~req_string_last;

`include "utf8_to_glyph_byte_transcoder_core_macros.svh"

   `U2G_ASSERT_IMP(a_glyph_nonzero, clock, reset, rsp_valid_ff && gvalid_ff, gbyte_ff != '0)
   `U2G_ASSERT_NXT(a_last_clears, clock, reset, last_beat, count_ff == '0 && pend_ff == 2'd0)
   `U2G_ASSERT_IMP(a_stall_only_full, clock, reset, !rsp_valid_ff, !req_stall)
   `U2G_ASSERT_NXT(a_count_inc, clock, reset, body_beat, count_ff - $past(count_ff) <= COUNT_BITS'(1))

endmodule
